/* hdl/pfp_pkg.sv */
// Package for the particulate frame parser: frame layout constants and
// output word layout. No dependencies.
package pfp_pkg;

	localparam int unsigned FrameLen  = 32;
	localparam int unsigned SumEnd    = 30;
	localparam int unsigned WordFirst = 4;
	localparam int unsigned WordBytes = 12;
	localparam int unsigned WordCount = 6;

	localparam int unsigned PosW  = $clog2(FrameLen);
	localparam int unsigned WordW = 16;
	localparam int unsigned KW    = $clog2(WordCount);

	// output word: six readings, ok flag, mismatch count, padded to bytes
	localparam int unsigned OutBits = WordCount * WordW + 1 + WordW;
	localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

	localparam logic [PosW-1:0] PosLast      = PosW'(FrameLen - 1);
	localparam logic [PosW-1:0] PosSumEnd    = PosW'(SumEnd);
	localparam logic [PosW-1:0] PosWordFirst = PosW'(WordFirst);
	localparam logic [PosW-1:0] PosWordEnd   = PosW'(WordFirst + WordBytes);

	typedef logic [WordW-1:0] word_t;

endpackage

/* hdl/particulate_frame_parser.sv */
// Particulate frame parser top level: byte input stage, frame state and
// result register. Depends on pfp_pkg.
//
// The block counts received bytes into fixed 32-byte frames from the first
// byte after reset, with no header search. Bytes 0..29 are summed modulo
// 65536, bytes 4..15 give six big-endian 16-bit readings and bytes 30..31
// are the big-endian checksum. After byte 31 one result word comes out: the
// held readings (replaced only by a frame whose checksum matches), a
// checksum-ok flag and a saturating mismatch count. One byte is taken every
// cycle unless the stall below holds; each byte passes one input register and
// then the add/compare logic, and the result register takes a result when its
// last byte advances out of the input register. The only stall is a finished
// result at the output while the byte that would close the next frame waits.
module particulate_frame_parser
	import pfp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [7:0]      s_axis_tdata,  // [7:0] rx_byte
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// [15:0] pm1_standard, [31:16] pm25_standard, [47:32] pm10_standard,
	// [63:48] pm1_ambient, [79:64] pm25_ambient, [95:80] pm10_ambient,
	// [96] frame_ok, [112:97] mismatch_total, [119:113] zero
	output logic [OutW-1:0] m_axis_tdata
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            advance_s1;
	logic            last_s1;

	logic [PosW-1:0] pos_q;
	word_t           sum_q;
	word_t           words_q [WordCount];
	logic [7:0]      cks_hi_q;
	word_t           held_q [WordCount];
	word_t           mis_q;

	logic            out_valid_q;
	logic [OutW-1:0] out_data_q;

	logic [PosW-1:0] widx;
	logic [KW-1:0]   wk;
	logic            in_words;
	logic            ok;
	word_t           mis_next;
	word_t           held_next [WordCount];
	logic [OutW-1:0] out_next;

	// stall only when a frame closes while the result register is full
	assign last_s1       = (pos_q == PosLast);
	assign advance_s1    = !(valid_s1 && last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// decode byte position
	assign widx     = pos_q - PosWordFirst;
	assign wk       = widx[KW:1];
	assign in_words = (pos_q >= PosWordFirst) && (pos_q < PosWordEnd);
	assign ok       = ({cks_hi_q, byte_s1} == sum_q);
	assign mis_next = (!ok && mis_q != '1) ? mis_q + word_t'(1) : mis_q;

	always_comb begin
		for (int i = 0; i < WordCount; i++) begin
			held_next[i] = ok ? words_q[i] : held_q[i];
		end
		out_next = '0;
		for (int i = 0; i < WordCount; i++) begin
			out_next[i*WordW +: WordW] = held_next[i];
		end
		out_next[WordCount*WordW]                 = ok;
		out_next[WordCount*WordW + 1 +: WordW]    = mis_next;
	end

	// frame state: position, sum, checksum, counter, held readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			cks_hi_q <= '0;
			mis_q    <= '0;
			for (int i = 0; i < WordCount; i++) begin
				words_q[i] <= '0;
				held_q[i]  <= '0;
			end
		end else if (valid_s1 && advance_s1) begin
			pos_q <= pos_q + PosW'(1);
			if (pos_q < PosSumEnd) begin
				sum_q <= sum_q + word_t'(byte_s1);
			end
			if (pos_q == PosSumEnd) begin
				cks_hi_q <= byte_s1;
			end
			if (in_words) begin
				for (int i = 0; i < WordCount; i++) begin
					if (wk == KW'(i)) begin
						if (!widx[0]) begin
							words_q[i] <= {byte_s1, 8'h00};
						end else begin
							words_q[i] <= {words_q[i][WordW-1:8], byte_s1};
						end
					end
				end
			end
			if (last_s1) begin
				sum_q <= '0;
				mis_q <= mis_next;
				for (int i = 0; i < WordCount; i++) begin
					held_q[i] <= held_next[i];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1 && last_s1) begin
			out_data_q <= out_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// mismatch count never goes down
	a_mis_mono: assert property (@(posedge clk) disable iff (!arst_n)
		mis_q >= $past(mis_q))
		else $error("mismatch count decreased");

	// a new result only follows a frame's last byte
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without closing byte");

	// a bad frame leaves a nonzero mismatch count
	a_bad_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q[WordCount*WordW]) |->
			(out_data_q[WordCount*WordW + 1 +: WordW] != '0))
		else $error("bad frame with zero mismatch count");

endmodule

/* test/particulate_frame_parser_tb.sv */
// Testbench for particulate_frame_parser: streams 32-byte sensor frames in,
// predicts each frame result and checks every output word field by field.
// Depends on pfp_pkg and the particulate_frame_parser RTL.
module particulate_frame_parser_tb;
	import pfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_ALT} fill_e;
	typedef enum {SUM_GOOD, SUM_BAD, SUM_ONES, SUM_RAND} sum_e;

	typedef struct {
		word_t rd [WordCount];
		logic  ok;
		word_t mism;
	} frame_result_t;

	typedef struct {
		fill_e fill;
		sum_e  sum;
		bit    typed;
		word_t rd;
		logic  ok;
		word_t cnt;
	} frame_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [7:0]      s_axis_tdata = '0;  // [7:0] rx_byte
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	// [15:0] pm1_standard ... [95:80] pm10_ambient, [96] frame_ok,
	// [112:97] mismatch_total, [119:113] zero
	logic [OutW-1:0] m_axis_tdata;

	particulate_frame_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [PosW-1:0] frame_pos = '0;
	word_t           frame_sum = '0;
	word_t           capture [WordCount];
	logic [7:0]      cks_high = '0;
	word_t           held [WordCount];
	word_t           bad_frames = '0;

	frame_result_t   pending_results [$];
	logic [7:0]      frame_buf [FrameLen];
	int unsigned     mismatches = 0;
	int unsigned     cycles = 0;
	bit              quiet = 1'b0;
	bit              calm = 1'b0;
	int unsigned     stall_left = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	// advance the frame predictor by one byte; returns 1 when a frame closes
	function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
		int unsigned k;
		bit good;
		if (frame_pos < PosSumEnd)
			frame_sum = frame_sum + word_t'(b);
		if (frame_pos >= PosWordFirst && frame_pos < PosWordEnd) begin
			k = (int'(frame_pos) - int'(WordFirst)) >> 1;
			if (frame_pos[0] == PosWordFirst[0])
				capture[k] = {b, 8'h00};
			else
				capture[k] = {capture[k][15:8], b};
		end
		if (frame_pos == PosSumEnd)
			cks_high = b;
		if (frame_pos != PosLast) begin
			frame_pos = frame_pos + 1'b1;
			return 1'b0;
		end
		good = ({cks_high, b} == frame_sum);
		if (good)
			held = capture;
		else if (bad_frames != 16'hFFFF)
			bad_frames = bad_frames + 1'b1;
		r.rd = held;
		r.ok = good;
		r.mism = bad_frames;
		frame_pos = '0;
		frame_sum = '0;
		return 1'b1;
	endfunction

	// fill the frame buffer and patch the checksum bytes unless the kind is SUM_RAND
	task automatic fill_frame(input fill_e fill, input sum_e kind);
		word_t s;
		s = '0;
		for (int i = 0; i < FrameLen; i++) begin
			case (fill)
				FILL_ZERO: frame_buf[i] = 8'h00;
				FILL_ONES: frame_buf[i] = 8'hFF;
				FILL_RAND: frame_buf[i] = 8'($urandom_range(0, 255));
				default:   frame_buf[i] = i[0] ? 8'h55 : 8'hAA;
			endcase
			if (i < SumEnd)
				s = s + word_t'(frame_buf[i]);
		end
		case (kind)
			SUM_GOOD: {frame_buf[30], frame_buf[31]} = s;
			SUM_BAD:  {frame_buf[30], frame_buf[31]} = s ^ word_t'($urandom_range(1, 65535));
			SUM_ONES: {frame_buf[30], frame_buf[31]} = 16'hFFFF;
			default: ;
		endcase
	endtask

	// offer one byte, with an optional gap first, and predict it on acceptance
	task automatic send_byte(input logic [7:0] b, output bit closed, output frame_result_t r);
		int unsigned gap;
		if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		closed = parse_byte(b, r);
	endtask

	task automatic send_frame(input frame_row_t row);
		bit closed;
		frame_result_t r;
		for (int i = 0; i < FrameLen; i++) begin
			send_byte(frame_buf[i], closed, r);
			if (closed) begin
				if (row.typed) begin
					foreach (r.rd[k])
						r.rd[k] = row.rd;
					r.ok = row.ok;
					r.mism = row.cnt;
				end
				pending_results.push_back(r);
			end
		end
	endtask

	// drop valid and hold until every expected result has come
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// check results and drive the output ready with random stalls
	always @(posedge clk) begin
		frame_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			foreach (got.rd[k])
				got.rd[k] = m_axis_tdata[k*WordW +: WordW];
			got.ok = m_axis_tdata[WordCount*WordW];
			got.mism = m_axis_tdata[WordCount*WordW+1 +: WordW];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, frame_ok", got.ok, 0);
			end else begin
				want = pending_results.pop_front();
				foreach (got.rd[k])
					if (got.rd[k] !== want.rd[k])
						report_mismatch($sformatf("reading %0d", k), got.rd[k], want.rd[k]);
				if (got.ok !== want.ok)
					report_mismatch("frame_ok", got.ok, want.ok);
				if (got.mism !== want.mism)
					report_mismatch("mismatch_total", got.mism, want.mism);
			end
		end
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("particulate_frame_parser_tb failed");
			$finish;
		end
	end

	initial begin
		frame_row_t plan [8];
		frame_row_t row;
		int unsigned pick;
		foreach (capture[k]) begin
			capture[k] = '0;
			held[k] = '0;
		end
		// zeros, all-ones with wrong checksum, all-ones with right checksum,
		// bad frame keeping old readings, then predicted frames
		plan[0] = '{FILL_ZERO, SUM_GOOD, 1'b1, 16'h0000, 1'b1, 16'd0};
		plan[1] = '{FILL_ONES, SUM_ONES, 1'b1, 16'h0000, 1'b0, 16'd1};
		plan[2] = '{FILL_ONES, SUM_GOOD, 1'b1, 16'hFFFF, 1'b1, 16'd1};
		plan[3] = '{FILL_RAND, SUM_BAD,  1'b1, 16'hFFFF, 1'b0, 16'd2};
		plan[4] = '{FILL_RAND, SUM_GOOD, 1'b0, 16'h0000, 1'b0, 16'd0};
		plan[5] = '{FILL_ALT,  SUM_GOOD, 1'b0, 16'h0000, 1'b0, 16'd0};
		plan[6] = '{FILL_ZERO, SUM_ONES, 1'b0, 16'h0000, 1'b0, 16'd0};
		plan[7] = '{FILL_ALT,  SUM_BAD,  1'b0, 16'h0000, 1'b0, 16'd0};

		// hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		foreach (plan[n]) begin
			fill_frame(plan[n].fill, plan[n].sum);
			send_frame(plan[n]);
		end

		// random frames: mostly well formed, some bad checksums and raw noise
		row = '{FILL_RAND, SUM_GOOD, 1'b0, 16'h0000, 1'b0, 16'd0};
		for (int n = 0; n < 36; n++) begin
			calm = ($urandom_range(0, 3) == 0);
			quiet = (n >= 30);
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				fill_frame(FILL_RAND, SUM_GOOD);
			else if (pick <= 7)
				fill_frame(FILL_RAND, SUM_BAD);
			else if (pick == 8)
				fill_frame(FILL_RAND, SUM_RAND);
			else
				fill_frame(fill_e'($urandom_range(0, 3)), SUM_GOOD);
			send_frame(row);
			if (n == 12)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("particulate_frame_parser_tb passed");
		else
			$display("particulate_frame_parser_tb failed");
		$finish;
	end

endmodule

/* particulate_frame_parser.f */
hdl/pfp_pkg.sv
hdl/particulate_frame_parser.sv
test/particulate_frame_parser_tb.sv
